FILE: rtl/wpps_pkg.sv
`default_nettype none
package wpps_pkg;

    // Storage geometry.
    localparam int NUM_VTX  = 1024;
    localparam int VTX_AW   = 10;
    localparam int NUM_EDGE = 8192;
    localparam int EDGE_AW  = 13;

    // Field and datapath widths.
    localparam int CNT_W    = 14;
    localparam int RANK_W   = 32;
    localparam int VC_W     = 11;
    localparam int DAMP_W   = 25;
    localparam int FRAC_W   = 24;
    localparam int SUM_W    = 46;
    localparam int PROD_W   = DAMP_W + FRAC_W;
    localparam int ACC_W    = DAMP_W + 1;
    localparam int NR_W     = 48;
    localparam int ERRS_W   = 43;
    localparam int DCNT_W   = 6;
    localparam int CFG_IW   = 2;

    // Configuration register indexes.
    localparam logic [CFG_IW-1:0] CFG_VCOUNT  = 2'd0;
    localparam logic [CFG_IW-1:0] CFG_EPSILON = 2'd1;
    localparam logic [CFG_IW-1:0] CFG_DAMPING = 2'd2;
    localparam logic [CFG_IW-1:0] CFG_BASE    = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [VC_W-1:0]   VCOUNT_RST  = 11'd1024;
    localparam logic [RANK_W-1:0] EPSILON_RST = 32'd168;
    localparam logic [DAMP_W-1:0] DAMPING_RST = 25'd14260634;
    localparam logic [DAMP_W-1:0] BASE_RST    = 25'd2516582;

    typedef enum logic [2:0] {
        MODE_VERTEX  = 3'd0,
        MODE_IN_EDGE = 3'd1,
        MODE_OUT_EDGE = 3'd2,
        MODE_CONTRIB = 3'd3,
        MODE_READ    = 3'd4,
        MODE_SWEEP   = 3'd5
    } mode_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_VX,
        ST_VCHK,
        ST_IN,
        ST_INE,
        ST_INC,
        ST_M1,
        ST_M2,
        ST_M3,
        ST_ERR,
        ST_OUT,
        ST_OUTE,
        ST_DGO,
        ST_DIV,
        ST_RES,
        ST_CLR
    } state_t;

    typedef struct packed {
        logic              start;
        logic [ERRS_W-1:0] dividend;
        logic [VC_W-1:0]   divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [ERRS_W-1:0] quotient;
    } div_rsp_t;

endpackage
`default_nettype wire

FILE: rtl/wpps_ram.sv
`default_nettype none
module wpps_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

FILE: rtl/wpps_div.sv
`default_nettype none
module wpps_div (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire wpps_pkg::div_req_t req,
    output wpps_pkg::div_rsp_t      rsp
);

    logic [wpps_pkg::ERRS_W-1:0] quo_reg, quo_next;
    logic [wpps_pkg::VC_W-1:0]   rem_reg, rem_next;
    logic [wpps_pkg::VC_W-1:0]   dvs_reg, dvs_next;
    logic [wpps_pkg::DCNT_W-1:0] cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [wpps_pkg::VC_W:0]     trial;
    logic [wpps_pkg::VC_W:0]     diff;

    // Restoring division, one quotient bit per cycle.
    always_comb begin
        trial     = {rem_reg, quo_reg[wpps_pkg::ERRS_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = wpps_pkg::DCNT_W'(wpps_pkg::ERRS_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (!diff[wpps_pkg::VC_W]) begin
                rem_next = diff[wpps_pkg::VC_W-1:0];
            end else begin
                rem_next = trial[wpps_pkg::VC_W-1:0];
            end
            quo_next  = {quo_reg[wpps_pkg::ERRS_W-2:0], ~diff[wpps_pkg::VC_W]};
            cnt_next  = cnt_reg - 1'b1;
            if (cnt_reg == wpps_pkg::DCNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule
`default_nettype wire

FILE: rtl/worklist_pagerank_pull_sweep_unit.sv
// Load transactions (modes 0 to 3) write their store when accepted; a read rank transaction
// passes RD1 and RD2 before its result is registered. A sweep visits every vertex, sums the
// in-edges of active ones, walks out-edges where the error reaches epsilon, runs the mean divider
// and clears the next worklist; one sequencer walks all stores, each with a write and a read port.
// After reset the block clears both worklist banks before taking a transaction.
// Configuration registers reset to their defaults; the graph stores are undefined until written.
`default_nettype none
module worklist_pagerank_pull_sweep_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [2:0]  s_mode,
    input  wire logic [9:0]  s_vertex,
    input  wire logic [12:0] s_edge_slot,
    input  wire logic [9:0]  s_neighbour,
    input  wire logic [12:0] s_in_start,
    input  wire logic [13:0] s_in_count,
    input  wire logic [12:0] s_out_start,
    input  wire logic [13:0] s_out_count,
    input  wire logic [31:0] s_rank_value,
    input  wire logic [31:0] s_contribution,
    input  wire logic        s_active,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_read_rank,
    output logic [10:0]      m_active_count,
    output logic [31:0]      m_mean_error,
    output logic             m_is_sweep
);

    wpps_pkg::state_t state_reg, state_next;

    // Configuration registers.
    logic [wpps_pkg::VC_W-1:0]   vcount_reg;
    logic [wpps_pkg::RANK_W-1:0] eps_reg;
    logic [wpps_pkg::DAMP_W-1:0] damp_reg;
    logic [wpps_pkg::DAMP_W-1:0] base_reg;

    // Sweep datapath registers.
    logic [wpps_pkg::VC_W-1:0]    x_reg;
    logic [wpps_pkg::CNT_W-1:0]   j_reg;
    logic [wpps_pkg::EDGE_AW-1:0] istart_reg, ostart_reg;
    logic [wpps_pkg::CNT_W-1:0]   icount_reg, ocount_reg;
    logic [wpps_pkg::RANK_W-1:0]  oldr_reg, newr_reg;
    logic [wpps_pkg::SUM_W-1:0]   sum_reg;
    logic [wpps_pkg::PROD_W-1:0]  prod_reg;
    logic [wpps_pkg::ACC_W-1:0]   acc_reg;
    logic [wpps_pkg::ERRS_W-1:0]  errs_reg;
    logic [wpps_pkg::VC_W-1:0]    cnt_reg;
    logic [wpps_pkg::VTX_AW-1:0]  clr_reg;
    logic                         clr_both_reg;
    logic                         sel_reg;

    // Output register.
    logic                        m_valid_reg;
    logic [wpps_pkg::RANK_W-1:0] rd_rank_reg;
    logic [wpps_pkg::VC_W-1:0]   act_reg;
    logic [wpps_pkg::RANK_W-1:0] mean_reg;
    logic                        sweep_reg;

    logic                        accept, out_free;
    logic [wpps_pkg::VC_W-1:0]   n_eff;
    logic [wpps_pkg::RANK_W-1:0] err;
    logic                        err_hit;
    logic [wpps_pkg::NR_W-1:0]   nr_sum;
    logic [wpps_pkg::DAMP_W-1:0] mul_a;
    logic [wpps_pkg::FRAC_W-1:0] mul_b;
    logic [wpps_pkg::PROD_W-1:0] mul_p;
    logic [wpps_pkg::RANK_W-1:0] mean_sat;

    // Memory ports.
    logic                         rank_we, cont_we, vtx_we, ie_we, oe_we;
    logic [wpps_pkg::VTX_AW-1:0]  rank_wa, cont_ra;
    logic [wpps_pkg::RANK_W-1:0]  rank_wd, rank_q, cont_q;
    logic [wpps_pkg::EDGE_AW-1:0] istart_q, ostart_q, ie_ra, oe_ra;
    logic [wpps_pkg::CNT_W-1:0]   icount_q, ocount_q;
    logic [wpps_pkg::VTX_AW-1:0]  ie_q, oe_q;
    logic                         wl0_we, wl1_we, wl0_wd, wl1_wd, wl0_q, wl1_q, wl_cur_q;
    logic [wpps_pkg::VTX_AW-1:0]  wl0_wa, wl1_wa;
    logic                         wl_cur_we, wl_nxt_we, wl_clr;
    logic [wpps_pkg::VTX_AW-1:0]  wl_cur_wa, wl_nxt_wa;

    wpps_pkg::div_req_t div_req;
    wpps_pkg::div_rsp_t div_rsp;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign n_eff    = (vcount_reg > wpps_pkg::VC_W'(wpps_pkg::NUM_VTX))
                      ? wpps_pkg::VC_W'(wpps_pkg::NUM_VTX) : vcount_reg;

    // Shared multiplier: damping times the low, then the high half of the sum.
    assign mul_a = damp_reg;
    assign mul_b = (state_reg == wpps_pkg::ST_M1) ? sum_reg[wpps_pkg::FRAC_W-1:0]
                   : wpps_pkg::FRAC_W'(sum_reg[wpps_pkg::SUM_W-1:wpps_pkg::FRAC_W]);
    assign mul_p = wpps_pkg::PROD_W'(mul_a) * wpps_pkg::PROD_W'(mul_b);

    assign nr_sum  = wpps_pkg::NR_W'(prod_reg) + wpps_pkg::NR_W'(acc_reg);
    assign err     = (newr_reg >= oldr_reg) ? newr_reg - oldr_reg : oldr_reg - newr_reg;
    assign err_hit = err >= eps_reg;
    assign mean_sat = (n_eff == '0) ? '0
                      : (|div_rsp.quotient[wpps_pkg::ERRS_W-1:wpps_pkg::RANK_W]) ? '1
                      : div_rsp.quotient[wpps_pkg::RANK_W-1:0];

    // Next-state logic of the sequencer.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            wpps_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_mode == wpps_pkg::MODE_READ) begin
                        state_next = wpps_pkg::ST_RD1;
                    end else if (s_mode == wpps_pkg::MODE_SWEEP) begin
                        state_next = wpps_pkg::ST_VX;
                    end
                end
            end
            wpps_pkg::ST_RD1: state_next = wpps_pkg::ST_RD2;
            wpps_pkg::ST_RD2: begin
                if (out_free) begin
                    state_next = wpps_pkg::ST_IDLE;
                end
            end
            wpps_pkg::ST_VX: begin
                state_next = (x_reg == n_eff) ? wpps_pkg::ST_DGO : wpps_pkg::ST_VCHK;
            end
            wpps_pkg::ST_VCHK: state_next = wl_cur_q ? wpps_pkg::ST_IN : wpps_pkg::ST_VX;
            wpps_pkg::ST_IN: begin
                state_next = (j_reg == icount_reg) ? wpps_pkg::ST_M1 : wpps_pkg::ST_INE;
            end
            wpps_pkg::ST_INE: state_next = wpps_pkg::ST_INC;
            wpps_pkg::ST_INC: state_next = wpps_pkg::ST_IN;
            wpps_pkg::ST_M1:  state_next = wpps_pkg::ST_M2;
            wpps_pkg::ST_M2:  state_next = wpps_pkg::ST_M3;
            wpps_pkg::ST_M3:  state_next = wpps_pkg::ST_ERR;
            wpps_pkg::ST_ERR: state_next = err_hit ? wpps_pkg::ST_OUT : wpps_pkg::ST_VX;
            wpps_pkg::ST_OUT: begin
                state_next = (j_reg == ocount_reg) ? wpps_pkg::ST_VX : wpps_pkg::ST_OUTE;
            end
            wpps_pkg::ST_OUTE: state_next = wpps_pkg::ST_OUT;
            wpps_pkg::ST_DGO:  state_next = wpps_pkg::ST_DIV;
            wpps_pkg::ST_DIV: begin
                if (div_rsp.done) begin
                    state_next = wpps_pkg::ST_RES;
                end
            end
            wpps_pkg::ST_RES: begin
                if (out_free) begin
                    state_next = wpps_pkg::ST_CLR;
                end
            end
            wpps_pkg::ST_CLR: begin
                if (clr_reg == wpps_pkg::VTX_AW'(wpps_pkg::NUM_VTX - 1)) begin
                    state_next = wpps_pkg::ST_IDLE;
                end
            end
            default: state_next = wpps_pkg::ST_IDLE;
        endcase
    end

    // Memory controls and handshake outputs.
    always_comb begin
        s_ready   = (state_reg == wpps_pkg::ST_IDLE);
        vtx_we    = accept && (s_mode == wpps_pkg::MODE_VERTEX);
        ie_we     = accept && (s_mode == wpps_pkg::MODE_IN_EDGE);
        oe_we     = accept && (s_mode == wpps_pkg::MODE_OUT_EDGE);
        cont_we   = accept && (s_mode == wpps_pkg::MODE_CONTRIB);
        rank_we   = vtx_we || ((state_reg == wpps_pkg::ST_ERR) && err_hit);
        rank_wa   = s_ready ? s_vertex : x_reg[wpps_pkg::VTX_AW-1:0];
        rank_wd   = s_ready ? s_rank_value : newr_reg;
        cont_ra   = ie_q;
        ie_ra     = istart_reg + j_reg[wpps_pkg::EDGE_AW-1:0];
        oe_ra     = ostart_reg + j_reg[wpps_pkg::EDGE_AW-1:0];
        wl_cur_we = vtx_we;
        wl_cur_wa = s_vertex;
        wl_nxt_we = (state_reg == wpps_pkg::ST_OUTE);
        wl_nxt_wa = oe_q;
        wl_clr    = (state_reg == wpps_pkg::ST_CLR);
        div_req.start    = (state_reg == wpps_pkg::ST_DGO);
        div_req.dividend = errs_reg;
        div_req.divisor  = n_eff;
    end

    // Worklist banks: sel_reg names the current one, the other collects the next worklist.
    always_comb begin
        wl_cur_q = sel_reg ? wl1_q : wl0_q;
        wl0_we = 1'b0;
        wl0_wa = clr_reg;
        wl0_wd = 1'b0;
        wl1_we = 1'b0;
        wl1_wa = clr_reg;
        wl1_wd = 1'b0;
        if (wl_clr) begin
            wl0_we = clr_both_reg || sel_reg;
            wl1_we = clr_both_reg || !sel_reg;
        end else if (wl_cur_we) begin
            if (sel_reg) begin
                wl1_we = 1'b1;
                wl1_wa = wl_cur_wa;
                wl1_wd = s_active;
            end else begin
                wl0_we = 1'b1;
                wl0_wa = wl_cur_wa;
                wl0_wd = s_active;
            end
        end else if (wl_nxt_we) begin
            if (sel_reg) begin
                wl0_we = 1'b1;
                wl0_wa = wl_nxt_wa;
                wl0_wd = 1'b1;
            end else begin
                wl1_we = 1'b1;
                wl1_wa = wl_nxt_wa;
                wl1_wd = 1'b1;
            end
        end
    end

    // Control state and configuration.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= wpps_pkg::ST_CLR;
            clr_reg      <= '0;
            clr_both_reg <= 1'b1;
            sel_reg      <= 1'b0;
            m_valid_reg  <= 1'b0;
            vcount_reg   <= wpps_pkg::VCOUNT_RST;
            eps_reg      <= wpps_pkg::EPSILON_RST;
            damp_reg     <= wpps_pkg::DAMPING_RST;
            base_reg     <= wpps_pkg::BASE_RST;
        end else begin
            state_reg <= state_next;
            if (cfg_we) begin
                case (cfg_index)
                    wpps_pkg::CFG_VCOUNT:  vcount_reg <= cfg_data[wpps_pkg::VC_W-1:0];
                    wpps_pkg::CFG_EPSILON: eps_reg    <= cfg_data;
                    wpps_pkg::CFG_DAMPING: damp_reg   <= cfg_data[wpps_pkg::DAMP_W-1:0];
                    wpps_pkg::CFG_BASE:    base_reg   <= cfg_data[wpps_pkg::DAMP_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == wpps_pkg::ST_CLR) begin
                clr_reg <= clr_reg + 1'b1;
                if (clr_reg == wpps_pkg::VTX_AW'(wpps_pkg::NUM_VTX - 1)) begin
                    clr_both_reg <= 1'b0;
                end
            end
            // The next worklist becomes current once the sweep result is out.
            if ((state_reg == wpps_pkg::ST_RES) && out_free) begin
                sel_reg <= !sel_reg;
                clr_reg <= '0;
            end
            if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (((state_reg == wpps_pkg::ST_RES) || (state_reg == wpps_pkg::ST_RD2))
                && out_free) begin
                m_valid_reg <= 1'b1;
            end
        end
    end

    // Sweep and result datapath.
    always_ff @(posedge aclk) begin
        case (state_reg)
            wpps_pkg::ST_IDLE: begin
                if (accept) begin
                    x_reg    <= (s_mode == wpps_pkg::MODE_READ)
                                ? wpps_pkg::VC_W'(s_vertex) : '0;
                    cnt_reg  <= '0;
                    errs_reg <= '0;
                end
            end
            wpps_pkg::ST_RD2: begin
                if (out_free) begin
                    rd_rank_reg <= rank_q;
                    act_reg     <= '0;
                    mean_reg    <= '0;
                    sweep_reg   <= 1'b0;
                end
            end
            wpps_pkg::ST_VCHK: begin
                istart_reg <= istart_q;
                icount_reg <= icount_q;
                ostart_reg <= ostart_q;
                ocount_reg <= ocount_q;
                oldr_reg   <= rank_q;
                sum_reg    <= '0;
                j_reg      <= '0;
                if (!wl_cur_q) begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            wpps_pkg::ST_INC: begin
                sum_reg <= sum_reg + wpps_pkg::SUM_W'(cont_q);
                j_reg   <= j_reg + 1'b1;
            end
            wpps_pkg::ST_M1: prod_reg <= mul_p;
            wpps_pkg::ST_M2: begin
                acc_reg  <= wpps_pkg::ACC_W'(prod_reg[wpps_pkg::PROD_W-1:wpps_pkg::FRAC_W])
                            + wpps_pkg::ACC_W'(base_reg);
                prod_reg <= mul_p;
            end
            wpps_pkg::ST_M3: begin
                newr_reg <= (|nr_sum[wpps_pkg::NR_W-1:wpps_pkg::RANK_W]) ? '1
                            : nr_sum[wpps_pkg::RANK_W-1:0];
            end
            wpps_pkg::ST_ERR: begin
                errs_reg <= errs_reg + wpps_pkg::ERRS_W'(err);
                j_reg    <= '0;
                if (err_hit) begin
                    cnt_reg <= cnt_reg + 1'b1;
                end else begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            wpps_pkg::ST_OUT: begin
                if (j_reg == ocount_reg) begin
                    x_reg <= x_reg + 1'b1;
                end
            end
            wpps_pkg::ST_OUTE: j_reg <= j_reg + 1'b1;
            wpps_pkg::ST_RES: begin
                if (out_free) begin
                    rd_rank_reg <= '0;
                    act_reg     <= cnt_reg;
                    mean_reg    <= mean_sat;
                    sweep_reg   <= 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_read_rank    = rd_rank_reg;
    assign m_active_count = act_reg;
    assign m_mean_error   = mean_reg;
    assign m_is_sweep     = sweep_reg;

    // Graph stores.
    wpps_ram #(.WIDTH(wpps_pkg::RANK_W), .DEPTH(wpps_pkg::NUM_VTX)) u_rank (
        .aclk(aclk), .we(rank_we), .waddr(rank_wa), .wdata(rank_wd),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(rank_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::RANK_W), .DEPTH(wpps_pkg::NUM_VTX)) u_contrib (
        .aclk(aclk), .we(cont_we), .waddr(s_vertex), .wdata(s_contribution),
        .raddr(cont_ra), .rdata(cont_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::EDGE_AW), .DEPTH(wpps_pkg::NUM_VTX)) u_in_start (
        .aclk(aclk), .we(vtx_we), .waddr(s_vertex), .wdata(s_in_start),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(istart_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::CNT_W), .DEPTH(wpps_pkg::NUM_VTX)) u_in_count (
        .aclk(aclk), .we(vtx_we), .waddr(s_vertex), .wdata(s_in_count),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(icount_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::EDGE_AW), .DEPTH(wpps_pkg::NUM_VTX)) u_out_start (
        .aclk(aclk), .we(vtx_we), .waddr(s_vertex), .wdata(s_out_start),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(ostart_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::CNT_W), .DEPTH(wpps_pkg::NUM_VTX)) u_out_count (
        .aclk(aclk), .we(vtx_we), .waddr(s_vertex), .wdata(s_out_count),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(ocount_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::VTX_AW), .DEPTH(wpps_pkg::NUM_EDGE)) u_in_edge (
        .aclk(aclk), .we(ie_we), .waddr(s_edge_slot), .wdata(s_neighbour),
        .raddr(ie_ra), .rdata(ie_q)
    );
    wpps_ram #(.WIDTH(wpps_pkg::VTX_AW), .DEPTH(wpps_pkg::NUM_EDGE)) u_out_edge (
        .aclk(aclk), .we(oe_we), .waddr(s_edge_slot), .wdata(s_neighbour),
        .raddr(oe_ra), .rdata(oe_q)
    );
    wpps_ram #(.WIDTH(1), .DEPTH(wpps_pkg::NUM_VTX)) u_wl0 (
        .aclk(aclk), .we(wl0_we), .waddr(wl0_wa), .wdata(wl0_wd),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(wl0_q)
    );
    wpps_ram #(.WIDTH(1), .DEPTH(wpps_pkg::NUM_VTX)) u_wl1 (
        .aclk(aclk), .we(wl1_we), .waddr(wl1_wa), .wdata(wl1_wd),
        .raddr(x_reg[wpps_pkg::VTX_AW-1:0]), .rdata(wl1_q)
    );

    // Mean error divider.
    wpps_div u_div (
        .aclk(aclk), .aresetn(aresetn), .req(div_req), .rsp(div_rsp)
    );

    // The active count never exceeds the vertices already visited.
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wpps_pkg::ST_VX) |-> (cnt_reg <= x_reg))
        else $error("active count exceeds visited vertices");

    // The vertex walk never passes the vertex count.
    a_walk_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == wpps_pkg::ST_VX) |-> (x_reg <= n_eff))
        else $error("vertex walk ran past the vertex count");

    // A delivered sweep result is always followed by the worklist clear.
    a_clear_after: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == wpps_pkg::ST_RES) && out_free) |=> (state_reg == wpps_pkg::ST_CLR))
        else $error("sweep result not followed by worklist clear");

    // A read result shows up flagged as a read.
    a_read_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == wpps_pkg::ST_RD2) && out_free) |=> (m_valid && !m_is_sweep))
        else $error("read result missing or misflagged");

    // The divider is only started when it is free.
    a_div_free: assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> !div_rsp.busy)
        else $error("divider restarted while busy");

endmodule
`default_nettype wire
